>>> rtl/core/device_liveness_table_assert.svh
// ----------------------------------------------------------------------------
// Device liveness table assertion macros
// Shorthand for the concurrent checks used inside the RTL. Each macro expects
// signals named clock and reset in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef DEVICE_LIVENESS_TABLE_ASSERT_SVH
`define DEVICE_LIVENESS_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DLT_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("device liveness table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DLT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("device liveness table: next-cycle check failed");

`endif

>>> rtl/core/dlt_pkg.sv
// ----------------------------------------------------------------------------
// Device liveness table package
// Shared widths, codes and types of the liveness table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dlt_pkg;

   localparam int TABLE_SLOTS_DEF = 16;
   localparam int REPORT_CAP      = 16;
   localparam int RPT_W           = $clog2(REPORT_CAP + 1);
   localparam int ID_W            = 8;
   localparam int PAYLOAD_W       = 32;
   localparam int AGE_W           = 16;
   localparam int CSR_W           = 16;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [AGE_W-1:0] STALE_TICKS_RESET = 16'd5;
   localparam logic [AGE_W-1:0] LOST_TICKS_RESET  = 16'd10;

   localparam logic OP_KEEPALIVE = 1'b0;
   localparam logic OP_TICK      = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STALE_TICKS = 1'b0,
      CSR_LOST_TICKS  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_FOUND    = 2'd0,
      EV_REJOINED = 2'd1,
      EV_LOST     = 2'd2,
      EV_FULL     = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_KA_DONE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] payload;
      logic [AGE_W-1:0]     age;
   } slot_entry_type;

   typedef struct packed {
      event_type            ev;
      logic [ID_W-1:0]      id;
      logic [PAYLOAD_W-1:0] payload;
   } report_type;

   typedef struct packed {
      logic [AGE_W-1:0] age;
      logic             over;
   } age_eval_type;

endpackage

`default_nettype wire

>>> rtl/core/dlt_slot_mem.sv
// ----------------------------------------------------------------------------
// Liveness table slot memory
// Holds id, announcement word and age of every slot. One write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dlt_slot_mem #(
   parameter int TABLE_SLOTS = dlt_pkg::TABLE_SLOTS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(TABLE_SLOTS)-1:0]   wr_addr,
   input  wire dlt_pkg::slot_entry_type          wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(TABLE_SLOTS)-1:0]   rd_addr,
   output dlt_pkg::slot_entry_type               rd_data
);

   dlt_pkg::slot_entry_type entry_ram [TABLE_SLOTS];
   dlt_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ram[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/dlt_age_unit.sv
// ----------------------------------------------------------------------------
// Liveness table age unit
// Saturating age increment and threshold compare, shared by all slots.
// ----------------------------------------------------------------------------
`default_nettype none

module dlt_age_unit (
   input  wire logic [dlt_pkg::AGE_W-1:0] age_cur,
   input  wire logic [dlt_pkg::AGE_W-1:0] limit,
   output dlt_pkg::age_eval_type          result
);

   logic [dlt_pkg::AGE_W-1:0] age_next;

   assign age_next    = (age_cur == '1) ? age_cur : age_cur + dlt_pkg::AGE_W'(1);
   assign result.age  = age_next;
   assign result.over = age_next > limit;

endmodule

`default_nettype wire

>>> rtl/core/dlt_scan_ctrl.sv
// ----------------------------------------------------------------------------
// Liveness table scan sequencer
// Walks the slot memory one slot a cycle for lookup and aging unless a lost report
// is held, keeps valid and stale marks, delivers report beats with the last mark.
// ----------------------------------------------------------------------------
`default_nettype none
`include "device_liveness_table_assert.svh"

module dlt_scan_ctrl #(
   parameter int TABLE_SLOTS = dlt_pkg::TABLE_SLOTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [dlt_pkg::ID_W-1:0]          req_device_id,
   input  wire logic [dlt_pkg::PAYLOAD_W-1:0]     req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_event_res,
   output logic [dlt_pkg::ID_W-1:0]               rsp_device_id_res,
   output logic [dlt_pkg::PAYLOAD_W-1:0]          rsp_payload_res,
   output logic                                   rsp_last,
   input  wire logic [dlt_pkg::AGE_W-1:0]         stale_ticks,
   input  wire logic [dlt_pkg::AGE_W-1:0]         lost_ticks,
   output logic                                   mem_wr_en,
   output logic [$clog2(TABLE_SLOTS)-1:0]         mem_wr_addr,
   output dlt_pkg::slot_entry_type                mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [$clog2(TABLE_SLOTS)-1:0]         mem_rd_addr,
   input  wire dlt_pkg::slot_entry_type           mem_rd_data,
   output logic [dlt_pkg::AGE_W-1:0]              age_cur,
   output logic [dlt_pkg::AGE_W-1:0]              age_limit,
   input  wire dlt_pkg::age_eval_type             age_res
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(TABLE_SLOTS);
   localparam logic [dlt_pkg::RPT_W-1:0] RPT_LIMIT = dlt_pkg::RPT_W'(dlt_pkg::REPORT_CAP);

   dlt_pkg::state_type                state_ff, state_in;
   logic                              op_ff, op_in;
   logic [dlt_pkg::ID_W-1:0]          id_ff, id_in;
   logic [dlt_pkg::PAYLOAD_W-1:0]     pl_ff, pl_in;
   logic [CNT_W-1:0]                  a_idx_ff, a_idx_in;
   logic                              b_valid_ff, b_valid_in;
   logic [IDX_W-1:0]                  b_idx_ff, b_idx_in;
   logic                              hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]                  hit_idx_ff, hit_idx_in;
   logic                              free_found_ff, free_found_in;
   logic [IDX_W-1:0]                  free_idx_ff, free_idx_in;
   logic [dlt_pkg::RPT_W-1:0]         rpt_cnt_ff, rpt_cnt_in;
   logic [TABLE_SLOTS-1:0]            slot_valid_ff, slot_valid_in;
   logic [TABLE_SLOTS-1:0]            slot_stale_ff, slot_stale_in;
   logic                              pend_valid_ff, pend_valid_in;
   dlt_pkg::report_type               pend_ff, pend_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   dlt_pkg::report_type               rsp_ff, rsp_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             out_free;
   logic             a_live;
   logic             b_slot_valid;
   logic             b_slot_stale;
   logic             b_tick_live;
   logic             need_rpt;
   logic             blocked;
   logic             advance;
   logic             scan_done;
   logic [IDX_W-1:0] ka_tgt_idx;
   logic             ka_store;
   logic             ka_rpt;
   logic             ka_go;
   logic             drain_go;

   assign req_stall    = state_ff != dlt_pkg::ST_IDLE;
   assign req_accept   = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign a_live       = a_idx_ff != SLOT_END;
   assign b_slot_valid = slot_valid_ff[b_idx_ff];
   assign b_slot_stale = slot_stale_ff[b_idx_ff];
   assign age_cur      = mem_rd_data.age;
   assign age_limit    = b_slot_stale ? lost_ticks : stale_ticks;
   assign b_tick_live  = (state_ff == dlt_pkg::ST_SCAN) && b_valid_ff &&
                         (op_ff == dlt_pkg::OP_TICK) && b_slot_valid;
   assign need_rpt     = b_tick_live && b_slot_stale && age_res.over &&
                         (rpt_cnt_ff < RPT_LIMIT);
   assign blocked      = need_rpt && pend_valid_ff && !out_free;
   assign advance      = (state_ff == dlt_pkg::ST_SCAN) && !blocked;
   assign scan_done    = !a_live && !b_valid_ff;
   assign ka_tgt_idx   = hit_found_ff ? hit_idx_ff : free_idx_ff;
   assign ka_store     = hit_found_ff || free_found_ff;
   assign ka_rpt       = hit_found_ff ? slot_stale_ff[hit_idx_ff] : 1'b1;
   assign ka_go        = (state_ff == dlt_pkg::ST_KA_DONE) && (!ka_rpt || out_free);
   assign drain_go     = (state_ff == dlt_pkg::ST_DRAIN) && (!pend_valid_ff || out_free);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dlt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = dlt_pkg::ST_SCAN;
            end
         end
         dlt_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = (op_ff == dlt_pkg::OP_TICK) ? dlt_pkg::ST_DRAIN
                                                      : dlt_pkg::ST_KA_DONE;
            end
         end
         dlt_pkg::ST_KA_DONE: begin
            if (ka_go) begin
               state_in = dlt_pkg::ST_IDLE;
            end
         end
         dlt_pkg::ST_DRAIN: begin
            if (drain_go) begin
               state_in = dlt_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      mem_rd_en   = advance && a_live;
      mem_rd_addr = a_idx_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = b_idx_ff;
      mem_wr_data = mem_rd_data;
      if (ka_go && ka_store) begin
         mem_wr_en           = 1'b1;
         mem_wr_addr         = ka_tgt_idx;
         mem_wr_data.id      = id_ff;
         mem_wr_data.payload = pl_ff;
         mem_wr_data.age     = '0;
      end else if (advance && b_tick_live) begin
         mem_wr_en       = 1'b1;
         mem_wr_data.age = age_res.age;
      end
   end

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      pl_in         = pl_ff;
      a_idx_in      = a_idx_ff;
      b_valid_in    = b_valid_ff;
      b_idx_in      = b_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rpt_cnt_in    = rpt_cnt_ff;
      slot_valid_in = slot_valid_ff;
      slot_stale_in = slot_stale_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_accept) begin
         op_in         = req_op;
         id_in         = req_device_id;
         pl_in         = req_payload;
         a_idx_in      = '0;
         b_valid_in    = 1'b0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         rpt_cnt_in    = '0;
         pend_valid_in = 1'b0;
      end

      if (advance) begin
         b_valid_in = a_live;
         b_idx_in   = a_idx_ff[IDX_W-1:0];
         if (a_live) begin
            a_idx_in = a_idx_ff + CNT_W'(1);
         end
         if (b_valid_ff) begin
            if (op_ff == dlt_pkg::OP_KEEPALIVE) begin
               if (b_slot_valid && !hit_found_ff && (mem_rd_data.id == id_ff)) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = b_idx_ff;
               end
               if (!b_slot_valid && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = b_idx_ff;
               end
            end else if (b_slot_valid) begin
               if (!b_slot_stale && age_res.over) begin
                  slot_stale_in[b_idx_ff] = 1'b1;
               end
               if (need_rpt) begin
                  slot_valid_in[b_idx_ff] = 1'b0;
                  rpt_cnt_in              = rpt_cnt_ff + dlt_pkg::RPT_W'(1);
                  pend_valid_in           = 1'b1;
                  pend_in.ev              = dlt_pkg::EV_LOST;
                  pend_in.id              = mem_rd_data.id;
                  pend_in.payload         = mem_rd_data.payload;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                     rsp_last_in  = 1'b0;
                  end
               end
            end
         end
      end

      if (drain_go && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end

      if (ka_go) begin
         if (ka_store) begin
            slot_valid_in[ka_tgt_idx] = 1'b1;
            slot_stale_in[ka_tgt_idx] = 1'b0;
         end
         if (ka_rpt) begin
            rsp_valid_in   = 1'b1;
            rsp_in.id      = id_ff;
            rsp_in.payload = pl_ff;
            rsp_last_in    = 1'b1;
            if (hit_found_ff) begin
               rsp_in.ev = dlt_pkg::EV_REJOINED;
            end else if (free_found_ff) begin
               rsp_in.ev = dlt_pkg::EV_FOUND;
            end else begin
               rsp_in.ev = dlt_pkg::EV_FULL;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dlt_pkg::ST_IDLE;
         b_valid_ff    <= 1'b0;
         slot_valid_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         b_valid_ff    <= b_valid_in;
         slot_valid_ff <= slot_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      pl_ff         <= pl_in;
      a_idx_ff      <= a_idx_in;
      b_idx_ff      <= b_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rpt_cnt_ff    <= rpt_cnt_in;
      slot_stale_ff <= slot_stale_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_ff.ev;
   assign rsp_device_id_res = rsp_ff.id;
   assign rsp_payload_res   = rsp_ff.payload;
   assign rsp_last          = rsp_last_ff;

   // The write of the slot under evaluation never meets the read of the next one.
   `DLT_ASSERT_NOW(a_mem_port_apart, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
   `DLT_ASSERT_NEXT(a_accept_starts_scan, req_accept, state_ff == dlt_pkg::ST_SCAN)
   `DLT_ASSERT_NOW(a_pend_in_tick, pend_valid_ff,
      (state_ff == dlt_pkg::ST_SCAN) || (state_ff == dlt_pkg::ST_DRAIN))
   // A beat that is not the last one is always followed by more of the same item.
   `DLT_ASSERT_NOW(a_more_beats_follow, rsp_valid_ff && !rsp_last_ff,
      pend_valid_ff && ((state_ff == dlt_pkg::ST_SCAN) || (state_ff == dlt_pkg::ST_DRAIN)))

endmodule

`default_nettype wire

>>> rtl/core/device_liveness_table.sv
// An accepted beat runs through ST_SCAN, then ST_KA_DONE or ST_DRAIN, before its last report, if any, is presented.
// req_stall holds new beats off until the item is done, and longer while rsp_stall holds reports.
// Each item walks every slot once through the single read port of the slot memory.
// Reset clears all slot valid marks at once and sets stale_ticks to 5, lost_ticks to 10.
// There is no clearing pass; the block takes a beat in the cycle after reset.
// ----------------------------------------------------------------------------
// Device liveness table
// Heartbeat table of up to TABLE_SLOTS devices with keepalive lookup and
// tick driven aging, reporting found, rejoined, lost and table full events.
// ----------------------------------------------------------------------------
`default_nettype none

module device_liveness_table #(
   parameter int TABLE_SLOTS = dlt_pkg::TABLE_SLOTS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_op,
   input  wire logic [dlt_pkg::ID_W-1:0]             req_device_id,
   input  wire logic [dlt_pkg::PAYLOAD_W-1:0]        req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_event_res,
   output logic [dlt_pkg::ID_W-1:0]                  rsp_device_id_res,
   output logic [dlt_pkg::PAYLOAD_W-1:0]             rsp_payload_res,
   output logic                                      rsp_last,
   input  wire logic                                 csr_we,
   input  wire logic [dlt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [dlt_pkg::CSR_W-1:0]            csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   logic [dlt_pkg::AGE_W-1:0] stale_ticks_ff, stale_ticks_in;
   logic [dlt_pkg::AGE_W-1:0] lost_ticks_ff, lost_ticks_in;

   logic                      mem_wr_en;
   logic [IDX_W-1:0]          mem_wr_addr;
   dlt_pkg::slot_entry_type   mem_wr_data;
   logic                      mem_rd_en;
   logic [IDX_W-1:0]          mem_rd_addr;
   dlt_pkg::slot_entry_type   mem_rd_data;
   logic [dlt_pkg::AGE_W-1:0] age_cur;
   logic [dlt_pkg::AGE_W-1:0] age_limit;
   dlt_pkg::age_eval_type     age_res;

   always_comb begin
      stale_ticks_in = stale_ticks_ff;
      lost_ticks_in  = lost_ticks_ff;
      if (csr_we) begin
         unique case (csr_index)
            dlt_pkg::CSR_STALE_TICKS: begin
               stale_ticks_in = csr_wdata;
            end
            dlt_pkg::CSR_LOST_TICKS: begin
               lost_ticks_in = csr_wdata;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_ticks_ff <= dlt_pkg::STALE_TICKS_RESET;
         lost_ticks_ff  <= dlt_pkg::LOST_TICKS_RESET;
      end else begin
         stale_ticks_ff <= stale_ticks_in;
         lost_ticks_ff  <= lost_ticks_in;
      end
   end

   dlt_slot_mem #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   dlt_age_unit u_age_unit (
      .age_cur (age_cur),
      .limit   (age_limit),
      .result  (age_res)
   );

   dlt_scan_ctrl #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_scan_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_device_id     (req_device_id),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_device_id_res (rsp_device_id_res),
      .rsp_payload_res   (rsp_payload_res),
      .rsp_last          (rsp_last),
      .stale_ticks       (stale_ticks_ff),
      .lost_ticks        (lost_ticks_ff),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .age_cur           (age_cur),
      .age_limit         (age_limit),
      .age_res           (age_res)
   );

endmodule

`default_nettype wire
